@@ src/mlta_pkg.sv @@
// Shared types and constants for the MAC learning table with aging.
// No dependencies; used by mlta_cell and mac_learning_table_with_aging.
`timescale 1ns / 1ps

package mlta_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int MAC_W = 48;
  localparam int VLAN_W = 12;
  localparam int PORT_W = 10;
  localparam int TIME_W = 64;
  localparam int CAP_W = 7;
  localparam int AGE_W = 20;
  localparam int NS_W = 30;
  localparam int LIMIT_W = AGE_W + NS_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;
  localparam int MCAST_BIT = 40;

  localparam logic [NS_W-1:0] NS_PER_SECOND = NS_W'(1000000000);

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_REFRESHED = 3'd1;
  localparam logic [2:0] ST_MOVED = 3'd2;
  localparam logic [2:0] ST_IGNORED = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;
  localparam logic [2:0] ST_AGED = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AGING = 2'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [MAC_W-1:0]  mac;
    logic [VLAN_W-1:0] vlan;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] last_seen;
  } entry_t;

endpackage

@@ src/mlta_cell.sv @@
// One table entry in the rotating ring of cells.
// Depends on mlta_pkg for the entry type.
`timescale 1ns / 1ps

module mlta_cell
  import mlta_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  logic   set_valid,
  input  entry_t din,
  output entry_t dout
);

  logic              valid;
  logic [MAC_W-1:0]  mac;
  logic [VLAN_W-1:0] vlan;
  logic [PORT_W-1:0] port;
  logic [TIME_W-1:0] last_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= din.valid;
    end else if (set_valid) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      mac <= din.mac;
      vlan <= din.vlan;
      port <= din.port;
      last_seen <= din.last_seen;
    end
  end

  assign dout = '{valid: valid, mac: mac, vlan: vlan, port: port, last_seen: last_seen};

endmodule

@@ src/mac_learning_table_with_aging.sv @@
// Top level of the MAC learning table: ring of entry cells plus scan control.
// Depends on mlta_pkg and mlta_cell.
`timescale 1ns / 1ps

// For every command (learn or aging pass), busy stays high from the edge
// that accepts it until a command can be accepted again: the ring of
// 64 entry cells rotates once past the compare unit, one entry per cycle,
// then the DONE state settles the result. The result appears on the output ports
// for one cycle with done high, during which busy is already low; the
// receiver cannot stall it. Configuration writes are always accepted.
module mac_learning_table_with_aging
  import mlta_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  mode,
  input  logic [VLAN_W-1:0]     vlan_id,
  input  logic [MAC_W-1:0]      source_mac,
  input  logic [PORT_W-1:0]     ingress_port,
  input  logic [TIME_W-1:0]     now_ns,
  output logic                  done,
  output logic [2:0]            status,
  output logic [PORT_W-1:0]     previous_port,
  output logic [CNT_W-1:0]      removed_count,
  output logic [CNT_W-1:0]      entry_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [CAP_W-1:0]   table_capacity;
  logic [AGE_W-1:0]   max_idle_sec;
  logic [LIMIT_W-1:0] limit;

  logic              op_age;
  logic              op_ignore;
  logic [VLAN_W-1:0] op_vlan;
  logic [MAC_W-1:0]  op_mac;
  logic [PORT_W-1:0] op_port;
  logic [TIME_W-1:0] op_now;

  logic [IDX_W-1:0]  step;
  logic              found;
  logic [PORT_W-1:0] old_port;
  logic              have_free;
  logic [IDX_W-1:0]  free_pos;
  logic [CNT_W-1:0]  removed;
  logic [CNT_W-1:0]  valid_count;

  entry_t cells [TABLE_DEPTH];
  entry_t head, tail;
  logic   shift;
  logic   accept;
  logic   add_now;
  logic   is_old, is_match, take_free;
  logic [TIME_W-1:0] age;
  logic [CNT_W-1:0]  cap_eff;

  assign accept = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_capacity <= CAP_W'(TABLE_DEPTH);
      max_idle_sec <= AGE_W'(300);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CAPACITY: table_capacity <= cfg_data[CAP_W-1:0];
        REG_AGING:    max_idle_sec <= cfg_data[AGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    limit <= LIMIT_W'(max_idle_sec) * LIMIT_W'(NS_PER_SECOND);
  end

  // The ring: cell i takes from cell i+1, the last cell takes from the compare unit.
  assign head = cells[0];
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_ring
    entry_t din_i;
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign din_i = tail;
    end else begin : g_mid
      assign din_i = cells[i+1];
    end
    mlta_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .set_valid (add_now && (free_pos == IDX_W'(i))),
      .din       (din_i),
      .dout      (cells[i])
    );
  end

  assign age = op_now - head.last_seen;
  assign cap_eff = (table_capacity > CAP_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : CNT_W'(table_capacity);

  always_comb begin
    is_old = op_age && head.valid && (age >= TIME_W'(limit));
    is_match = !op_age && !op_ignore && head.valid &&
               (head.vlan == op_vlan) && (head.mac == op_mac);
    // A free slot is filled with the new key right away but stays invalid
    // until the scan proves the key is new and the table has room.
    take_free = !op_age && !op_ignore && !head.valid && !have_free;
    tail = head;
    if (is_old) begin
      tail.valid = 1'b0;
    end
    if (is_match) begin
      tail.port = op_port;
      tail.last_seen = op_now;
    end
    if (take_free) begin
      tail.mac = op_mac;
      tail.vlan = op_vlan;
      tail.port = op_port;
      tail.last_seen = op_now;
    end
  end

  assign add_now = (state == S_DONE) && !op_age && !op_ignore && !found &&
                   have_free && (valid_count < cap_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_SCAN;
      S_SCAN: if (step == IDX_W'(TABLE_DEPTH - 1)) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != S_IDLE);
    shift = (state == S_SCAN);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_age <= mode;
      op_ignore <= source_mac[MCAST_BIT] || (source_mac == '0);
      op_vlan <= vlan_id;
      op_mac <= source_mac;
      op_port <= ingress_port;
      op_now <= now_ns;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      found <= 1'b0;
      have_free <= 1'b0;
      removed <= '0;
      valid_count <= '0;
    end else if (accept) begin
      step <= '0;
      found <= 1'b0;
      have_free <= 1'b0;
      removed <= '0;
    end else if (state == S_SCAN) begin
      step <= step + IDX_W'(1);
      if (is_match) found <= 1'b1;
      if (take_free) begin
        have_free <= 1'b1;
        free_pos <= step;
      end
      if (is_old) removed <= removed + CNT_W'(1);
    end else if (state == S_DONE) begin
      if (op_age) begin
        valid_count <= valid_count - removed;
      end else if (add_now) begin
        valid_count <= valid_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN && is_match) begin
      old_port <= head.port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      if (op_age) begin
        status <= ST_AGED;
        previous_port <= '0;
        removed_count <= removed;
        entry_count <= valid_count - removed;
      end else begin
        removed_count <= '0;
        entry_count <= add_now ? valid_count + CNT_W'(1) : valid_count;
        if (op_ignore) begin
          status <= ST_IGNORED;
          previous_port <= op_port;
        end else if (found) begin
          status <= (old_port == op_port) ? ST_REFRESHED : ST_MOVED;
          previous_port <= old_port;
        end else if (add_now) begin
          status <= ST_ADDED;
          previous_port <= op_port;
        end else begin
          status <= ST_FULL;
          previous_port <= op_port;
        end
      end
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && (state == S_SCAN))
    else $error("accepted command did not start a scan");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> done && !busy)
    else $error("result strobe missing after scan");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    valid_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_removed_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && op_age |-> removed <= valid_count)
    else $error("aging removed more entries than were valid");

endmodule
